>>> hdl/stable_priority_queue_defines.svh
// Assertion macros for the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// Package for the stable priority queue: sizes, codes and helper functions.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW        = $clog2(DEPTH + 1);
	localparam int NCLS      = 4;
	localparam int CLS_W     = 2;
	localparam int MA_W      = CLS_W + AW;
	localparam int MEM_DEPTH = NCLS << AW;

	localparam int VALUE_W  = 16;
	localparam int PRIO_W   = 3;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 24;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_PUSH_OK   = 2'd0,
		STAT_PUSH_FULL = 2'd1,
		STAT_POPPED    = 2'd2,
		STAT_POP_EMPTY = 2'd3
	} status_t;

	// Saturate the requested priority to 1..4 and map it to a class 0..3.
	function automatic logic [CLS_W-1:0] prio_class(input logic [PRIO_W-1:0] pr);
		logic [CLS_W-1:0] c;
		case (pr)
			3'd0, 3'd1: c = 2'd0;
			3'd2:       c = 2'd1;
			3'd3:       c = 2'd2;
			default:    c = 2'd3;
		endcase
		return c;
	endfunction

	function automatic logic [PRIO_W-1:0] class_prio(input logic [CLS_W-1:0] c);
		return PRIO_W'(c) + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

`default_nettype wire

>>> hdl/stable_priority_queue.sv
// Stable priority queue: one ring per priority class in a shared synchronous memory.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tuser: kind; tdata: value, priority_req
//  m_*      out  m_tvalid / m_tready  tuser: status; tdata: out_value, out_priority, occupancy
//
// A push writes the tail slot of its class ring.
// A pop reads the head slot from memory into a read register, which S_READ copies to the output register.
// Reset clears the pointers and counts; memory contents are not cleared.
// A result sits in the output register until taken; a new word is taken once that
// register is free or being emptied in the same cycle, and no pop is in S_READ.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_defines.svh"

module stable_priority_queue
	import spq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // value[15:0], priority_req[18:16], zero pad
	input  wire logic             s_tuser,  // kind
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // out_value[15:0], out_priority[18:16], occupancy[23:19]
	output logic [STATUS_W-1:0]   m_tuser   // status
);

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q  [NCLS];
	logic [AW-1:0] head_q [NCLS];
	logic [AW-1:0] tail_q [NCLS];
	logic [CW-1:0] total_q, total_d;

	logic [VALUE_W-1:0] mem_q [MEM_DEPTH];
	logic [VALUE_W-1:0] rd_data_q;
	logic [CLS_W-1:0]   pop_cls_q;

	logic                m_valid_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [PRIO_W-1:0]   out_prio_q;
	logic [STATUS_W-1:0] status_q;
	logic [OCC_W-1:0]    occ_q;

	logic               in_kind;
	logic [VALUE_W-1:0] in_value;
	logic [PRIO_W-1:0]  in_prio;
	logic [CLS_W-1:0]   push_cls, top_cls;
	logic               out_free, accept, full, empty, do_push, do_pop;

	assign in_kind  = s_tuser;
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_prio  = s_tdata[VALUE_W+PRIO_W-1:VALUE_W];
	assign push_cls = prio_class(in_prio);

	// highest non-empty class is the head of the whole queue
	always_comb begin
		if (cnt_q[3] != '0) begin
			top_cls = 2'd3;
		end else if (cnt_q[2] != '0) begin
			top_cls = 2'd2;
		end else if (cnt_q[1] != '0) begin
			top_cls = 2'd1;
		end else begin
			top_cls = 2'd0;
		end
	end

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign full     = (total_q == CW'(DEPTH));
	assign empty    = (total_q == '0);
	assign do_push  = accept && (in_kind == KIND_PUSH) && !full;
	assign do_pop   = accept && (in_kind == KIND_POP) && !empty;

	always_comb begin
		state_d = state_q;
		total_d = total_q;
		if (do_push) begin
			total_d = total_q + 1'b1;
		end else if (do_pop) begin
			total_d = total_q - 1'b1;
		end
		case (state_q)
			S_IDLE: begin
				if (do_pop) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < NCLS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			total_q <= total_d;
			for (int i = 0; i < NCLS; i++) begin
				if (do_push && (push_cls == CLS_W'(i))) begin
					cnt_q[i]  <= cnt_q[i] + 1'b1;
					tail_q[i] <= ptr_inc(tail_q[i]);
				end
				if (do_pop && (top_cls == CLS_W'(i))) begin
					cnt_q[i]  <= cnt_q[i] - 1'b1;
					head_q[i] <= ptr_inc(head_q[i]);
				end
			end
		end
	end

	// ring storage; one op in flight, so a read never meets a write to the same slot
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[MA_W'({push_cls, tail_q[push_cls]})] <= in_value;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_data_q <= mem_q[MA_W'({top_cls, head_q[top_cls]})];
			pop_cls_q <= top_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == S_READ) begin
			m_valid_q <= 1'b1;
		end else if (accept && !do_pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			out_value_q <= rd_data_q;
			out_prio_q  <= class_prio(pop_cls_q);
			status_q    <= STAT_POPPED;
			occ_q       <= OCC_W'(total_q);
		end else if (accept && !do_pop) begin
			out_value_q <= '0;
			out_prio_q  <= '0;
			occ_q       <= OCC_W'(total_d);
			if (in_kind == KIND_POP) begin
				status_q <= STAT_POP_EMPTY;
			end else if (full) begin
				status_q <= STAT_PUSH_FULL;
			end else begin
				status_q <= STAT_PUSH_OK;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {occ_q, out_prio_q, out_value_q};
	assign m_tuser  = status_q;

	`SPQ_ASSERT_NOW(a_count_sum, 1'b1, (({2'b00, cnt_q[0]} + {2'b00, cnt_q[1]} + {2'b00, cnt_q[2]} + {2'b00, cnt_q[3]}) == {2'b00, total_q}), "class counts disagree with total")
	`SPQ_ASSERT_NEXT(a_pop_reads, do_pop, (state_q == S_READ) && !m_valid_q, "pop did not enter memory read")
	`SPQ_ASSERT_NEXT(a_push_grows, do_push, total_q == CW'($past(total_q) + 1'b1), "push did not grow occupancy")

endmodule

`default_nettype wire
